// ----- design/spq_pkg.sv -----
package spq_pkg;

  localparam int CAPACITY   = 16;
  localparam int STAMP_BITS = 32;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam int ACTION_W = 2;
  localparam int ID_W     = 16;
  localparam int PRIO_W   = 16;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  localparam int IN_BITS  = ACTION_W + ID_W + PRIO_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = STATUS_W + ID_W + 1 + ID_W + PRIO_W + COUNT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [ACTION_W-1:0] ACT_INSERT  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_POP     = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_UPGRADE = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_MORE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     served_id;
    logic                front_valid;
    logic [ID_W-1:0]     front_id;
    logic [PRIO_W-1:0]   front_priority;
    logic [COUNT_W-1:0]  entry_count;
  } result_t;

endpackage

// ----- design/stable_min_priority_queue_core.sv -----
// each item runs a first scan over the slots, an apply step, a second scan and a done
// state that loads the output register; no new item is taken before that; both scans go
//   through a single priority/stamp comparator, one slot per cycle
// a finished result waits in the output register while the next item is taken
// reset (rst, synchronous, active high): queue empty, stamp counter zero, no result
module stable_min_priority_queue_core
  import spq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,  // action[1:0], item_id[17:2], priority_req[33:18]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata   // status[2:0], served_id[18:3], front_valid[19],
                                     // front_id[35:20], front_priority[51:36],
                                     // entry_count[56:52]
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN1 = 3'd1;
  localparam logic [2:0] S_APPLY = 3'd2;
  localparam logic [2:0] S_SCAN2 = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  logic [2:0] state;

  logic [CAPACITY-1:0]   slot_valid;
  logic [ID_W-1:0]       slot_id       [CAPACITY];
  logic [PRIO_W-1:0]     slot_priority [CAPACITY];
  logic [STAMP_BITS-1:0] slot_stamp    [CAPACITY];

  logic [CNT_W-1:0]      held_count;
  logic [STAMP_BITS-1:0] stamp_counter;

  logic [ACTION_W-1:0] req_action;
  logic [ID_W-1:0]     req_id;
  logic [PRIO_W-1:0]   req_prio;

  logic [IDX_W-1:0] idx;

  logic                  best_found;
  logic [IDX_W-1:0]      best_idx;
  logic [ID_W-1:0]       best_id;
  logic [PRIO_W-1:0]     best_prio;
  logic [STAMP_BITS-1:0] best_stamp;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;

  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     served_id;

  logic [ID_W-1:0]       cur_id;
  logic [PRIO_W-1:0]     cur_prio;
  logic [STAMP_BITS-1:0] cur_stamp;
  logic                  cand;
  logic                  urgent;
  logic [STAMP_BITS-1:0] stamp_next;
  result_t               res;

  assign cur_id    = slot_id[idx];
  assign cur_prio  = slot_priority[idx];
  assign cur_stamp = slot_stamp[idx];

  // first pass of an upgrade only looks at slots holding the requested id
  assign cand = slot_valid[idx] &&
                ((state != S_SCAN1) || (req_action != ACT_UPGRADE) || (cur_id == req_id));

  // shared comparator: strictly more urgent than the best so far
  assign urgent = (cur_prio < best_prio) ||
                  ((cur_prio == best_prio) && (cur_stamp < best_stamp));

  assign stamp_next = stamp_counter + STAMP_BITS'(1);

  assign s_tready = (state == S_IDLE);

  always_comb begin
    res.status         = status;
    res.served_id      = served_id;
    res.front_valid    = best_found;
    res.front_id       = best_found ? best_id : '0;
    res.front_priority = best_found ? best_prio : '0;
    res.entry_count    = COUNT_W'(held_count);
  end

  // output packing: struct puts status in the top bits, so rebuild lowest-first
  function automatic logic [OUT_W-1:0] pack_result(input result_t r);
    logic [OUT_W-1:0] v;
    v = '0;
    v[STATUS_W-1:0]                             = r.status;
    v[STATUS_W +: ID_W]                         = r.served_id;
    v[STATUS_W+ID_W]                            = r.front_valid;
    v[STATUS_W+ID_W+1 +: ID_W]                  = r.front_id;
    v[STATUS_W+2*ID_W+1 +: PRIO_W]              = r.front_priority;
    v[STATUS_W+2*ID_W+1+PRIO_W +: COUNT_W]      = r.entry_count;
    return v;
  endfunction

  logic [OUT_W-1:0] res_packed;
  assign res_packed = pack_result(res);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      slot_valid    <= '0;
      held_count    <= '0;
      stamp_counter <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_SCAN1;
          end
        end
        S_SCAN1: begin
          if (idx == LAST_IDX) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          state <= S_SCAN2;
          unique case (req_action)
            ACT_INSERT: begin
              if (held_count < CNT_W'(CAPACITY) && free_found) begin
                slot_valid[free_idx] <= 1'b1;
                held_count           <= held_count + CNT_W'(1);
                stamp_counter        <= stamp_next;
              end
            end
            ACT_POP: begin
              if (best_found) begin
                slot_valid[best_idx] <= 1'b0;
                held_count           <= held_count - CNT_W'(1);
              end
            end
            ACT_UPGRADE: begin
              if (held_count != '0 && best_found && best_prio > req_prio) begin
                stamp_counter <= stamp_next;
              end
            end
            default: begin
              slot_valid    <= '0;
              held_count    <= '0;
              stamp_counter <= '0;
            end
          endcase
        end
        S_SCAN2: begin
          if (idx == LAST_IDX) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload, slot contents and scan registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        req_action <= s_tdata[ACTION_W-1:0];
        req_id     <= s_tdata[ACTION_W +: ID_W];
        req_prio   <= s_tdata[ACTION_W+ID_W +: PRIO_W];
        idx        <= '0;
        best_found <= 1'b0;
        free_found <= 1'b0;
        status     <= ST_OK;
        served_id  <= '0;
      end
      S_SCAN1, S_SCAN2: begin
        if (cand && (!best_found || urgent)) begin
          best_found <= 1'b1;
          best_idx   <= idx;
          best_id    <= cur_id;
          best_prio  <= cur_prio;
          best_stamp <= cur_stamp;
        end
        if (!slot_valid[idx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= idx;
        end
        idx <= (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
      end
      S_APPLY: begin
        best_found <= 1'b0;
        case (req_action)
          ACT_INSERT: begin
            if (held_count < CNT_W'(CAPACITY) && free_found) begin
              slot_id[free_idx]       <= req_id;
              slot_priority[free_idx] <= req_prio;
              slot_stamp[free_idx]    <= stamp_next;
            end else begin
              status <= ST_FULL;
            end
          end
          ACT_POP: begin
            if (best_found) begin
              served_id <= best_id;
            end else begin
              status <= ST_EMPTY;
            end
          end
          ACT_UPGRADE: begin
            if (held_count == '0) begin
              status <= ST_EMPTY;
            end else if (!best_found) begin
              status <= ST_NOT_FOUND;
            end else if (best_prio <= req_prio) begin
              status <= ST_NOT_MORE;
            end else begin
              slot_priority[best_idx] <= req_prio;
              slot_stamp[best_idx]    <= stamp_next;
            end
          end
          default: begin
            status <= ST_OK;
          end
        endcase
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= res_packed;
        end
      end
      default: begin
        idx <= '0;
      end
    endcase
  end

  // sanity checks
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    (32'(held_count) == 32'($countones(slot_valid))))
    else $error("held count disagrees with valid bits");

  a_front_vs_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[STATUS_W+ID_W] == (m_tdata[STATUS_W+2*ID_W+1+PRIO_W +: COUNT_W] != '0)))
    else $error("front valid inconsistent with entry count");

  a_served_only_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[STATUS_W-1:0] != ST_OK) |-> (m_tdata[STATUS_W +: ID_W] == '0))
    else $error("served id set on a failed action");

  a_result_after_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_DONE)
    else $error("result issued outside done state");

endmodule
